[rtl/fjgo_pkg.sv]
// ----------------------------------------------------------------------------
// fjgo_pkg: shared types and constants of the four-joint gait oscillator
// Register map, sequencer types, datapath widths and the quarter-sine entry
// function used to build the sine ROM at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package fjgo_pkg;

  // defaults for the top-level parameters
  localparam int PHASE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;

  // configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int PHASE_STEP_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE        = 3'd0,
    CFG_PHASE_STEP    = 3'd1,
    CFG_SHOULDER_AMP  = 3'd2,
    CFG_ELBOW_AMP     = 3'd3,
    CFG_ELBOW_OFFSET  = 3'd4,
    CFG_SIDE_OFFSET   = 3'd5,
    CFG_SHOULDER_GAIN = 3'd6,
    CFG_ELBOW_GAIN    = 3'd7
  } cfg_idx_e;

  // datapath widths
  localparam int DRIVE_W    = 16;
  localparam int SINE_W     = 16;   // signed, +/-16384
  localparam int SINE_MAG_W = 15;   // table entry, 0..16384
  localparam int MUL_A_W    = 33;   // speed * amplitude fits here
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int TURN_W     = 32;
  localparam int TURN_SHIFT = 14;   // Q28 -> Q42
  localparam int FRAC_DROP  = 28;   // Q42 -> Q14
  localparam int RND_W      = PROD_W - FRAC_DROP;
  localparam int DRIVE_MAX  = 32767;
  localparam int DRIVE_MIN  = -32768;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_DROP - 1));

  // sequencer
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MUL_SA = 4'd0;  // speed * shoulder amp
  localparam logic [STEP_W-1:0] STEP_MUL_EA = 4'd1;  // speed * elbow amp
  localparam logic [STEP_W-1:0] STEP_MUL_ST = 4'd2;  // turn * shoulder gain
  localparam logic [STEP_W-1:0] STEP_MUL_ET = 4'd3;  // turn * elbow gain
  localparam logic [STEP_W-1:0] STEP_SW_RS  = 4'd4;  // right shoulder swing
  localparam logic [STEP_W-1:0] STEP_SW_RE  = 4'd5;  // right elbow swing
  localparam logic [STEP_W-1:0] STEP_SW_LS  = 4'd6;  // left shoulder swing
  localparam logic [STEP_W-1:0] STEP_SW_LE  = 4'd7;  // left elbow swing
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd8;  // last drive written

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CALC  = 2'd1,
    ST_WRITE = 2'd2
  } seq_state_e;

  typedef struct packed {
    logic              in_ready;
    logic              calc;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } ctrl_t;

  // quarter-wave sine table, Q1.14, Taylor series in Q30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210};

  function automatic logic [SINE_MAG_W-1:0] sine_entry(input int unsigned idx,
                                                       input int unsigned abits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    int              k;
    x    = ((64'(idx) * PI_HALF_Q30) + ((64'd1 << abits) >> 1)) >> abits;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[k];
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return SINE_MAG_W'(r);
  endfunction

endpackage

`default_nettype wire

[rtl/fjgo_sine_rom.sv]
// ----------------------------------------------------------------------------
// fjgo_sine_rom: full-turn sine lookup
// Folds the phase into a quarter-wave table index, reads the table and applies
// the quadrant sign. Output is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fjgo_sine_rom
  import fjgo_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int ADDR_BITS  = SINE_ADDR_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic [PHASE_BITS-1:0]    phase_i,
  output logic signed [SINE_W-1:0]      sine_o
);

  localparam int LUT_BITS = ADDR_BITS + 2;
  localparam int TAB_N    = 1 << ADDR_BITS;
  localparam logic [ADDR_BITS:0] TAB_N_V = {1'b1, {ADDR_BITS{1'b0}}};

  logic [LUT_BITS-1:0]         lut_addr;
  logic [1:0]                  quad;
  logic [ADDR_BITS:0]          idx_raw;
  logic [ADDR_BITS:0]          idx;
  logic [SINE_MAG_W-1:0]       mag;
  logic [SINE_MAG_W-1:0]       tab [TAB_N+1];
  logic signed [SINE_W-1:0]    sine_d;
  logic signed [SINE_W-1:0]    sine_q;

  // top bits pick quadrant and entry; short phases are padded below
  if (PHASE_BITS >= LUT_BITS) begin : g_addr_trunc
    assign lut_addr = phase_i[PHASE_BITS-1 -: LUT_BITS];
  end else begin : g_addr_pad
    assign lut_addr = {phase_i, {(LUT_BITS-PHASE_BITS){1'b0}}};
  end

  for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_tab
    localparam logic [SINE_MAG_W-1:0] ENTRY = sine_entry(gi, ADDR_BITS);
    assign tab[gi] = ENTRY;
  end

  always_comb begin
    quad    = lut_addr[LUT_BITS-1 -: 2];
    idx_raw = {1'b0, lut_addr[ADDR_BITS-1:0]};
    // odd quadrants run the table backwards
    idx     = quad[0] ? (TAB_N_V - idx_raw) : idx_raw;
    mag     = tab[idx];
    sine_d  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    sine_q <= sine_d;
  end

  assign sine_o = sine_q;

endmodule

`default_nettype wire

[rtl/fjgo_mul.sv]
// ----------------------------------------------------------------------------
// fjgo_mul: shared signed multiplier
// One 33x17 signed product per cycle, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fjgo_mul
  import fjgo_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]       prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[rtl/fjgo_ctrl.sv]
// ----------------------------------------------------------------------------
// fjgo_ctrl: item sequencer
// Accepts a beat, steps the shared multiplier through nine steps if it is enabled,
// then hands the drives to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fjgo_ctrl
  import fjgo_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic enable_i,
  input  wire logic out_free_i,
  output ctrl_t     ctrl_o
);

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // disabled beats skip the arithmetic
          state_d = enable_i ? ST_CALC : ST_WRITE;
        end
      end
      ST_CALC: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_d = '0;
    if (state_q == ST_CALC) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_comb begin
    ctrl_o.in_ready = (state_q == ST_IDLE);
    ctrl_o.calc     = (state_q == ST_CALC);
    ctrl_o.step     = step_q;
    ctrl_o.load_out = (state_q == ST_WRITE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

[rtl/four_joint_gait_oscillator.sv]
// ----------------------------------------------------------------------------
// four_joint_gait_oscillator: phase-accumulator gait oscillator
// Advances a wrapping phase per enabled beat and computes four saturated joint drives
// from sine lookups, amplitudes and turn gains on one shared multiplier.
//
//   channel  | signals                                        | dir
//   ---------+------------------------------------------------+-----
//   in       | in_valid_i/in_ready_o, speed_cmd_i, turn_cmd_i | in
//   out      | out_valid_o/out_ready_i, drives_valid_o,       | out
//            |   rgt/lft shoulder/elbow drive_o               |
//   cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i               | in
//
// An enabled beat runs from accept through nine multiplier steps (eight
// products plus the last drive) and one output load to the next ready.
// A disabled beat goes from accept straight to the output load.
// The output register holds a result while the next beat is being worked on;
// the load waits for out_ready_i when a result is still pending.
// Reset clears the phase, the config registers, the output valid flag and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module four_joint_gait_oscillator
  import fjgo_pkg::*;
#(
  parameter int PHASE_BITS           = PHASE_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [DRIVE_W-1:0]  speed_cmd_i,
  input  wire logic signed [DRIVE_W-1:0]  turn_cmd_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            drives_valid_o,
  output logic signed [DRIVE_W-1:0]       rgt_shoulder_drive_o,
  output logic signed [DRIVE_W-1:0]       rgt_elbow_drive_o,
  output logic signed [DRIVE_W-1:0]       lft_shoulder_drive_o,
  output logic signed [DRIVE_W-1:0]       lft_elbow_drive_o
);

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(DRIVE_MAX);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(DRIVE_MIN);

  // configuration registers
  logic                        enable_q;
  logic [PHASE_STEP_W-1:0]     phase_step_q;
  logic [CFG_DATA_W-1:0]       sh_amp_q, el_amp_q, el_off_q, side_off_q;
  logic signed [CFG_DATA_W-1:0] sh_gain_q, el_gain_q;

  // phase and scaled increments
  logic [PHASE_BITS-1:0]       phase_q, phase_d;
  logic [PHASE_BITS-1:0]       step_sc, el_off_sc, side_off_sc;
  logic [CFG_DATA_W-1:0]       step16;
  logic [PHASE_BITS-1:0]       rom_phase;

  // datapath
  ctrl_t                       ctrl;
  logic                        accept;
  logic                        en_q;
  logic signed [DRIVE_W-1:0]   speed_q, turn_q;
  logic signed [MUL_A_W-1:0]   mul_a, sa_q, ea_q;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [TURN_W-1:0]    st_q, et_q, turn_sel;
  logic                        turn_sub;
  logic signed [PROD_W-1:0]    turn_ext, turn_q42, sum;
  logic signed [RND_W-1:0]     rnd;
  logic signed [DRIVE_W-1:0]   drive_sat;
  logic signed [SINE_W-1:0]    rom_sine;
  logic signed [SINE_W-1:0]    sin_q [4];
  logic signed [DRIVE_W-1:0]   drv_q [4];

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        drives_valid_q;
  logic signed [DRIVE_W-1:0]   rs_q, re_q, ls_q, le_q;

  assign accept = in_valid_i && ctrl.in_ready;
  assign step16 = {{(CFG_DATA_W-PHASE_STEP_W){1'b0}}, phase_step_q};

  // turn fractions are given in 1/65536; rescale to the phase width
  if (PHASE_BITS == CFG_DATA_W) begin : g_sc_eq
    assign step_sc     = step16;
    assign el_off_sc   = el_off_q;
    assign side_off_sc = side_off_q;
  end else if (PHASE_BITS > CFG_DATA_W) begin : g_sc_up
    assign step_sc     = {step16, {(PHASE_BITS-CFG_DATA_W){1'b0}}};
    assign el_off_sc   = {el_off_q, {(PHASE_BITS-CFG_DATA_W){1'b0}}};
    assign side_off_sc = {side_off_q, {(PHASE_BITS-CFG_DATA_W){1'b0}}};
  end else begin : g_sc_dn
    assign step_sc     = step16[CFG_DATA_W-1 -: PHASE_BITS];
    assign el_off_sc   = el_off_q[CFG_DATA_W-1 -: PHASE_BITS];
    assign side_off_sc = side_off_q[CFG_DATA_W-1 -: PHASE_BITS];
  end

  fjgo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .enable_i   (enable_q),
    .out_free_i (!out_valid_q || out_ready_i),
    .ctrl_o     (ctrl)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      phase_step_q <= '0;
      sh_amp_q     <= '0;
      el_amp_q     <= '0;
      el_off_q     <= '0;
      side_off_q   <= '0;
      sh_gain_q    <= '0;
      el_gain_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:        enable_q     <= cfg_wdata_i[0];
        CFG_PHASE_STEP:    phase_step_q <= cfg_wdata_i[PHASE_STEP_W-1:0];
        CFG_SHOULDER_AMP:  sh_amp_q     <= cfg_wdata_i;
        CFG_ELBOW_AMP:     el_amp_q     <= cfg_wdata_i;
        CFG_ELBOW_OFFSET:  el_off_q     <= cfg_wdata_i;
        CFG_SIDE_OFFSET:   side_off_q   <= cfg_wdata_i;
        CFG_SHOULDER_GAIN: sh_gain_q    <= cfg_wdata_i;
        CFG_ELBOW_GAIN:    el_gain_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // phase advances at accept, so the sine steps see the new value
  always_comb begin
    phase_d = phase_q;
    if (accept && enable_q) begin
      phase_d = phase_q + step_sc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      en_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        en_q <= enable_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      speed_q <= speed_cmd_i;
      turn_q  <= turn_cmd_i;
    end
  end

  // sine reads overlap the first four products
  always_comb begin
    case (ctrl.step)
      STEP_MUL_SA: rom_phase = phase_q;
      STEP_MUL_EA: rom_phase = phase_q + el_off_sc;
      STEP_MUL_ST: rom_phase = phase_q + side_off_sc;
      STEP_MUL_ET: rom_phase = phase_q + side_off_sc + el_off_sc;
      default:     rom_phase = phase_q;
    endcase
  end

  fjgo_sine_rom #(
    .PHASE_BITS (PHASE_BITS),
    .ADDR_BITS  (SINE_TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .phase_i (rom_phase),
    .sine_o  (rom_sine)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      STEP_MUL_SA: begin
        mul_a = MUL_A_W'(speed_q);
        mul_b = $signed({1'b0, sh_amp_q});
      end
      STEP_MUL_EA: begin
        mul_a = MUL_A_W'(speed_q);
        mul_b = $signed({1'b0, el_amp_q});
      end
      STEP_MUL_ST: begin
        mul_a = MUL_A_W'(turn_q);
        mul_b = MUL_B_W'(sh_gain_q);
      end
      STEP_MUL_ET: begin
        mul_a = MUL_A_W'(turn_q);
        mul_b = MUL_B_W'(el_gain_q);
      end
      STEP_SW_RS: begin
        mul_a = sa_q;
        mul_b = MUL_B_W'(sin_q[0]);
      end
      STEP_SW_RE: begin
        mul_a = ea_q;
        mul_b = MUL_B_W'(sin_q[1]);
      end
      STEP_SW_LS: begin
        // left shoulder swing is inverted
        mul_a = sa_q;
        mul_b = -MUL_B_W'(sin_q[2]);
      end
      STEP_SW_LE: begin
        mul_a = ea_q;
        mul_b = MUL_B_W'(sin_q[3]);
      end
      default: ;
    endcase
  end

  fjgo_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // swing plus turn (minus turn on the left side) in Q42, round half up to Q14, saturate
  always_comb begin
    turn_sel = st_q;
    turn_sub = 1'b0;
    case (ctrl.step)
      STEP_SW_RE: turn_sel = st_q;
      STEP_SW_LS: turn_sel = et_q;
      STEP_SW_LE: begin
        turn_sel = st_q;
        turn_sub = 1'b1;
      end
      STEP_LAST: begin
        turn_sel = et_q;
        turn_sub = 1'b1;
      end
      default: ;
    endcase
    turn_ext = PROD_W'(turn_sel);
    turn_q42 = turn_ext <<< TURN_SHIFT;
    sum      = prod + (turn_sub ? -turn_q42 : turn_q42) + ROUND_HALF;
    rnd      = sum[PROD_W-1:FRAC_DROP];
    if (rnd > SAT_HI) begin
      drive_sat = SAT_HI[DRIVE_W-1:0];
    end else if (rnd < SAT_LO) begin
      drive_sat = SAT_LO[DRIVE_W-1:0];
    end else begin
      drive_sat = rnd[DRIVE_W-1:0];
    end
  end

  // the product of step k lands in prod during step k+1
  always_ff @(posedge clk_i) begin
    if (ctrl.calc) begin
      case (ctrl.step)
        STEP_MUL_EA: begin
          sa_q     <= prod[MUL_A_W-1:0];
          sin_q[0] <= rom_sine;
        end
        STEP_MUL_ST: begin
          ea_q     <= prod[MUL_A_W-1:0];
          sin_q[1] <= rom_sine;
        end
        STEP_MUL_ET: begin
          st_q     <= prod[TURN_W-1:0];
          sin_q[2] <= rom_sine;
        end
        STEP_SW_RS: begin
          et_q     <= prod[TURN_W-1:0];
          sin_q[3] <= rom_sine;
        end
        STEP_SW_RE: drv_q[0] <= drive_sat;
        STEP_SW_LS: drv_q[1] <= drive_sat;
        STEP_SW_LE: drv_q[2] <= drive_sat;
        STEP_LAST:  drv_q[3] <= drive_sat;
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      drives_valid_q <= en_q;
      rs_q           <= en_q ? drv_q[0] : '0;
      re_q           <= en_q ? drv_q[1] : '0;
      ls_q           <= en_q ? drv_q[2] : '0;
      le_q           <= en_q ? drv_q[3] : '0;
    end
  end

  assign in_ready_o           = ctrl.in_ready;
  assign out_valid_o          = out_valid_q;
  assign drives_valid_o       = drives_valid_q;
  assign rgt_shoulder_drive_o = rs_q;
  assign rgt_elbow_drive_o    = re_q;
  assign lft_shoulder_drive_o = ls_q;
  assign lft_elbow_drive_o    = le_q;

`ifndef SYNTHESIS
  a_no_accept_in_calc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.calc |-> !in_ready_o)
    else $error("input ready while sequencer is busy");

  a_phase_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && enable_q) |=>
      (phase_q == PHASE_BITS'($past(phase_q) + $past(step_sc))))
    else $error("phase did not advance by one step");

  a_phase_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && enable_q) |=> $stable(phase_q))
    else $error("phase moved without an enabled beat");

  a_disabled_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drives_valid_o) |->
      (rgt_shoulder_drive_o == '0 && rgt_elbow_drive_o == '0 &&
       lft_shoulder_drive_o == '0 && lft_elbow_drive_o == '0))
    else $error("disabled result carries nonzero drives");

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.calc |-> (ctrl.step <= STEP_LAST))
    else $error("sequencer step out of range");
`endif

endmodule

`default_nettype wire

[tb/sv/gait_drive_checker.sv]
// ----------------------------------------------------------------------------
// gait_drive_checker: result checker for the four-joint gait oscillator
// Tracks register writes and accepted command beats, keeps its own phase
// accumulator and quarter-sine table, predicts the four joint drives of each
// beat and compares every accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module gait_drive_checker
  import fjgo_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [DRIVE_W-1:0]  speed_cmd_i,
  input  logic signed [DRIVE_W-1:0]  turn_cmd_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       drives_valid_i,
  input  logic signed [DRIVE_W-1:0]  rgt_shoulder_drive_i,
  input  logic signed [DRIVE_W-1:0]  rgt_elbow_drive_i,
  input  logic signed [DRIVE_W-1:0]  lft_shoulder_drive_i,
  input  logic signed [DRIVE_W-1:0]  lft_elbow_drive_i,
  output int                         mismatches_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // block is checked at its default sizes: 65536 phase counts per turn
  localparam int              PH_W       = PHASE_BITS_DEF;
  localparam int              TAB_A      = SINE_ADDR_BITS_DEF;
  localparam int              TAB_N      = 1 << TAB_A;
  localparam longint unsigned QUARTER_Q30 = 64'd1686629713;  // pi/2 in Q30
  localparam longint          HALF_LSB   = 64'sd134217728;   // 0.5 LSB of Q14 in Q42

  typedef struct packed {
    logic                      active;
    logic signed [DRIVE_W-1:0] r_shoulder;
    logic signed [DRIVE_W-1:0] r_elbow;
    logic signed [DRIVE_W-1:0] l_shoulder;
    logic signed [DRIVE_W-1:0] l_elbow;
  } drive_set_t;

  longint quarter_sine [0:TAB_N];

  logic                      enable_r;
  logic [PHASE_STEP_W-1:0]   step_r;
  logic [15:0]               shoulder_amp_r;
  logic [15:0]               elbow_amp_r;
  logic [PH_W-1:0]           elbow_off_r;
  logic [PH_W-1:0]           side_off_r;
  logic signed [15:0]        shoulder_gain_r;
  logic signed [15:0]        elbow_gain_r;
  logic [PH_W-1:0]           gait_phase;

  drive_set_t expected_drives [$];
  int         mismatch_cnt = 0;
  int         pending_cnt  = 0;
  int         beat_no      = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  // quarter-wave table, Taylor series in Q30 rounded to Q14
  initial begin
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          r;
    for (int i = 0; i <= TAB_N; i++) begin
      x    = (64'(i) * QUARTER_Q30 + 64'(TAB_N / 2)) >> TAB_A;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 32768) >>> 16;
      if (r > 16384) begin
        r = 16384;
      end
      quarter_sine[i] = r;
    end
  end

  function automatic longint sine_q14(input logic [PH_W-1:0] ph);
    logic [TAB_A+1:0] pos;
    int               idx;
    longint           mag;
    pos = ph[PH_W-1 -: TAB_A+2];
    idx = int'(pos[TAB_A-1:0]);
    if (pos[TAB_A]) begin
      idx = TAB_N - idx;
    end
    mag = quarter_sine[idx];
    return pos[TAB_A+1] ? -mag : mag;
  endfunction

  // Q42 -> Q14, round half toward +inf, saturate
  function automatic logic signed [DRIVE_W-1:0] q14_saturate(input longint acc);
    longint q;
    q = (acc + HALF_LSB) >>> 28;
    if (q > DRIVE_MAX) begin
      q = DRIVE_MAX;
    end else if (q < DRIVE_MIN) begin
      q = DRIVE_MIN;
    end
    return q[DRIVE_W-1:0];
  endfunction

  function automatic drive_set_t predict_drives(input logic [PH_W-1:0] ph,
                                                input logic signed [DRIVE_W-1:0] speed,
                                                input logic signed [DRIVE_W-1:0] turn);
    drive_set_t      d;
    longint          spd;
    longint          trn;
    longint          s_amp;
    longint          e_amp;
    longint          s_gain;
    longint          e_gain;
    longint          s_swing;
    longint          e_swing;
    longint          s_turn;
    longint          e_turn;
    logic [PH_W-1:0] ph_left;
    d = '0;
    if (enable_r) begin
      spd     = speed;
      trn     = turn;
      s_amp   = shoulder_amp_r;
      e_amp   = elbow_amp_r;
      s_gain  = shoulder_gain_r;
      e_gain  = elbow_gain_r;
      s_swing = spd * s_amp;
      e_swing = spd * e_amp;
      s_turn  = trn * s_gain * 16384;
      e_turn  = trn * e_gain * 16384;
      ph_left = ph + side_off_r;
      d.active     = 1'b1;
      d.r_shoulder = q14_saturate(s_swing * sine_q14(ph) + s_turn);
      d.r_elbow    = q14_saturate(e_swing * sine_q14(ph + elbow_off_r) + e_turn);
      d.l_shoulder = q14_saturate(-(s_swing * sine_q14(ph_left)) - s_turn);
      d.l_elbow    = q14_saturate(e_swing * sine_q14(ph_left + elbow_off_r) - e_turn);
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] drive mismatch, result beat %0d: %s", $realtime, beat_no, msg);
  endtask

  task automatic check_field(input string name, input logic signed [DRIVE_W-1:0] got,
                             input logic signed [DRIVE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_set_t want;
    if (!rst_ni) begin
      enable_r        = 1'b0;
      step_r          = '0;
      shoulder_amp_r  = '0;
      elbow_amp_r     = '0;
      elbow_off_r     = '0;
      side_off_r      = '0;
      shoulder_gain_r = '0;
      elbow_gain_r    = '0;
      gait_phase      = '0;
      expected_drives.delete();
      pending_cnt     = 0;
    end else begin
      // retire first: a result never belongs to a beat taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result beat with no command beat outstanding");
        end else begin
          want = expected_drives.pop_front();
          check_field("drives_valid", DRIVE_W'(drives_valid_i), DRIVE_W'(want.active));
          check_field("rgt_shoulder", rgt_shoulder_drive_i, want.r_shoulder);
          check_field("rgt_elbow", rgt_elbow_drive_i, want.r_elbow);
          check_field("lft_shoulder", lft_shoulder_drive_i, want.l_shoulder);
          check_field("lft_elbow", lft_elbow_drive_i, want.l_elbow);
        end
        beat_no++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ENABLE:        enable_r        = cfg_wdata_i[0];
          CFG_PHASE_STEP:    step_r          = cfg_wdata_i[PHASE_STEP_W-1:0];
          CFG_SHOULDER_AMP:  shoulder_amp_r  = cfg_wdata_i;
          CFG_ELBOW_AMP:     elbow_amp_r     = cfg_wdata_i;
          CFG_ELBOW_OFFSET:  elbow_off_r     = cfg_wdata_i;
          CFG_SIDE_OFFSET:   side_off_r      = cfg_wdata_i;
          CFG_SHOULDER_GAIN: shoulder_gain_r = cfg_wdata_i;
          CFG_ELBOW_GAIN:    elbow_gain_r    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        // phase only moves while enabled
        if (enable_r) begin
          gait_phase = gait_phase + PH_W'(step_r);
        end
        expected_drives.push_back(predict_drives(gait_phase, speed_cmd_i, turn_cmd_i));
      end
      pending_cnt = expected_drives.size();
    end
  end

endmodule

[tb/sv/tb_four_joint_gait_oscillator.sv]
// ----------------------------------------------------------------------------
// tb_four_joint_gait_oscillator: testbench top of the gait oscillator
// Drives register settings and speed/turn command beats with bursty input and
// a randomly stalling result side, including long back-pressure stretches.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_four_joint_gait_oscillator
  import fjgo_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_PERIOD   = 8;
  localparam int     RESET_CYCLES = 3;
  localparam int     RANDOM_ITEMS = 1550;
  localparam int     RANDOM_SETS  = 10;
  localparam int     LONG_HOLD    = 300;
  localparam int     SETTLE       = 16;
  localparam longint TIMEOUT_NS   = 4_000_000;

  typedef struct {
    logic                    enable;
    logic [PHASE_STEP_W-1:0] step;
    logic [15:0]             s_amp;
    logic [15:0]             e_amp;
    logic [15:0]             e_off;
    logic [15:0]             side_off;
    logic [15:0]             s_gain;
    logic [15:0]             e_gain;
  } gait_cfg_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx      = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata    = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic signed [DRIVE_W-1:0] speed_cmd    = '0;
  logic signed [DRIVE_W-1:0] turn_cmd     = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic                      drives_valid;
  logic signed [DRIVE_W-1:0] rs_drive;
  logic signed [DRIVE_W-1:0] re_drive;
  logic signed [DRIVE_W-1:0] ls_drive;
  logic signed [DRIVE_W-1:0] le_drive;
  int                        mismatches;
  int                        pending;
  int                        hold_requests = 0;

  // speed/turn corner pairs
  logic signed [15:0] corner_speed [10] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000,
                                            16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                                            16'sh0001, 16'shFFFF};
  logic signed [15:0] corner_turn  [10] = '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000,
                                            16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                                            16'shFFFF, 16'sh0001};

  always #(CLK_PERIOD / 2) clk = ~clk;

  four_joint_gait_oscillator dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .speed_cmd_i          (speed_cmd),
    .turn_cmd_i           (turn_cmd),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .drives_valid_o       (drives_valid),
    .rgt_shoulder_drive_o (rs_drive),
    .rgt_elbow_drive_o    (re_drive),
    .lft_shoulder_drive_o (ls_drive),
    .lft_elbow_drive_o    (le_drive)
  );

  gait_drive_checker u_drive_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_we_i             (cfg_we),
    .cfg_idx_i            (cfg_idx),
    .cfg_wdata_i          (cfg_wdata),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .speed_cmd_i          (speed_cmd),
    .turn_cmd_i           (turn_cmd),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .drives_valid_i       (drives_valid),
    .rgt_shoulder_drive_i (rs_drive),
    .rgt_elbow_drive_i    (re_drive),
    .lft_shoulder_drive_i (ls_drive),
    .lft_elbow_drive_i    (le_drive),
    .mismatches_o         (mismatches),
    .pending_o            (pending)
  );

  function automatic logic signed [15:0] command_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic gait_cfg_t random_gait(input int k);
    gait_cfg_t c;
    c.enable   = ($urandom_range(0, 5) != 0);
    c.step     = PHASE_STEP_W'($urandom);
    c.s_amp    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    c.e_amp    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    c.e_off    = 16'($urandom);
    c.side_off = 16'($urandom);
    c.s_gain   = 16'($urandom);
    c.e_gain   = 16'($urandom);
    case (k)
      3: c = '{enable: 1'b1, step: '1, s_amp: 16'hFFFF, e_amp: 16'hFFFF, e_off: 16'hFFFF,
               side_off: 16'hFFFF, s_gain: 16'h7FFF, e_gain: 16'h8000};
      5: c.enable = 1'b0;
      7: c = '{enable: 1'b1, step: '0, s_amp: 16'h0000, e_amp: 16'h0000, e_off: 16'h0000,
               side_off: 16'h0000, s_gain: 16'h8000, e_gain: 16'h7FFF};
      8: begin
        c.enable = 1'b1;
        c.s_amp  = 16'h8000;
        c.e_amp  = 16'h8000;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // unused upper bits of enable and step carry junk
  task automatic program_gait(input gait_cfg_t c);
    write_reg(CFG_ENABLE, {15'($urandom), c.enable});
    write_reg(CFG_PHASE_STEP, {3'($urandom), c.step});
    write_reg(CFG_SHOULDER_AMP, c.s_amp);
    write_reg(CFG_ELBOW_AMP, c.e_amp);
    write_reg(CFG_ELBOW_OFFSET, c.e_off);
    write_reg(CFG_SIDE_OFFSET, c.side_off);
    write_reg(CFG_SHOULDER_GAIN, c.s_gain);
    write_reg(CFG_ELBOW_GAIN, c.e_gain);
  endtask

  task automatic send_cmd(input logic signed [15:0] speed, input logic signed [15:0] turn);
    @(negedge clk);
    in_valid  <= 1'b1;
    speed_cmd <= speed;
    turn_cmd  <= turn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // lower valid, then wait for every predicted beat to come back
  task automatic end_stream();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_corners(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_cmd(corner_speed[i], corner_turn[i]);
    end
  endtask

  task automatic drive_random_items(input int count);
    int burst;
    burst = $urandom_range(1, 24);
    for (int n = 0; n < count; n++) begin
      send_cmd(command_value(), command_value());
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          pause_input($urandom_range(1, 14));
        end
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin : result_drain
    int holds_done;
    int span;
    holds_done = 0;
    forever begin
      if (hold_requests > holds_done) begin
        // long back-pressure: output register and datapath fill, in_ready drops
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end
      span = $urandom_range(8, 40);
      case ($urandom_range(0, 3))
        0: begin
          @(negedge clk);
          out_ready <= 1'b1;
          repeat ($urandom_range(10, 80)) @(negedge clk);
        end
        1: begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat ($urandom_range(0, 11)) @(negedge clk);
        end
        2: repeat (span) begin
          @(negedge clk);
          out_ready <= 1'($urandom);
        end
        default: repeat (span) begin
          @(negedge clk);
          out_ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  initial begin : stimulus
    gait_cfg_t cfg;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // registers at reset: oscillator off, all drives zero
    repeat (3) send_cmd(command_value(), command_value());
    end_stream();

    // full-scale amplitudes and gains, largest step
    cfg = '{enable: 1'b1, step: '1, s_amp: 16'h8000, e_amp: 16'h8000, e_off: 16'h4000,
            side_off: 16'h8000, s_gain: 16'h7FFF, e_gain: 16'h8000};
    program_gait(cfg);
    send_corners(0, 9);
    end_stream();

    // amplitudes above nominal range, offsets just short of a turn, zero step
    cfg = '{enable: 1'b1, step: '0, s_amp: 16'hFFFF, e_amp: 16'hFFFF, e_off: 16'hFFFF,
            side_off: 16'hFFFF, s_gain: 16'h8000, e_gain: 16'h7FFF};
    program_gait(cfg);
    send_corners(4, 9);
    end_stream();

    // disabled with live settings: phase must hold, then resume
    write_reg(CFG_PHASE_STEP, {3'($urandom), 13'h10E1});
    write_reg(CFG_ENABLE, {15'($urandom), 1'b0});
    repeat (3) send_cmd(command_value(), command_value());
    end_stream();
    write_reg(CFG_ENABLE, {15'($urandom), 1'b1});
    repeat (2) send_cmd(command_value(), command_value());
    end_stream();

    for (int k = 0; k < RANDOM_SETS; k++) begin
      program_gait(random_gait(k));
      if (k == 1 || k == 6) begin
        hold_requests++;
      end
      drive_random_items(RANDOM_ITEMS / RANDOM_SETS);
      end_stream();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/fjgo_pkg.sv
rtl/fjgo_sine_rom.sv
rtl/fjgo_mul.sv
rtl/fjgo_ctrl.sv
rtl/four_joint_gait_oscillator.sv
tb/sv/gait_drive_checker.sv
tb/sv/tb_four_joint_gait_oscillator.sv
